// ----- src/assert_macros.svh -----
// Assertion helper macros shared by the RTL files of the indexed deque list.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, ignored while reset is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Property that must hold in the same cycle on every rising clock edge.
`define ASSERT_NOW(label, expr, msg) \
    `ASSERT_CLK(label, expr, msg)

`endif

// ----- src/idl_pkg.sv -----
// Shared types and constants for the indexed deque list.
// No dependencies; imported by idl_cell, indexed_deque_list, idl_checker and indexed_deque_list_tb.
`timescale 1ns / 1ps

package idl_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_INSERT     = 3'd4,
        KIND_ERASE      = 3'd5,
        KIND_SEARCH     = 3'd6,
        KIND_CLEAR      = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_ERASE  = 2'd2,
        CELL_SEARCH = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     write;
    } t_cell_ctl;

    typedef struct packed {
        logic match;
        logic last;
    } t_cell_stat;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_REPORT = 1'b1
    } t_state;

endpackage

// ----- src/idl_cell.sv -----
// One list slot: holds an entry, shifts with its neighbors and compares against a key.
// Depends on idl_pkg.
`timescale 1ns / 1ps

module idl_cell #(
    parameter int DATA_WIDTH = idl_pkg::DATA_WIDTH_DEF,
    parameter int CNT_W      = 5,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  idl_pkg::t_cell_ctl    i_ctl,
    input  logic [CNT_W-1:0]      i_pos,
    input  logic [CNT_W-1:0]      i_count,
    input  logic [DATA_WIDTH-1:0] i_key,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_data,
    output idl_pkg::t_cell_stat   o_stat
);
    import idl_pkg::*;

    localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(IDX + 1);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  r_match;
    logic                  n_match;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (IDX_C > i_pos) begin
                    n_data = i_left;
                end else if (IDX_C == i_pos) begin
                    n_data = i_key;
                end
            end
            CELL_ERASE: begin
                if (IDX_C >= i_pos) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
        n_match = (i_ctl.op == CELL_SEARCH) && (IDX_C < i_count) && (r_data == i_key);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.write) begin
            r_data <= n_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else begin
            r_match <= n_match;
        end
    end

    assign o_data       = r_data;
    assign o_stat.match = r_match;
    assign o_stat.last  = (i_count == IDX_P1);

endmodule

// ----- src/indexed_deque_list.sv -----
// Top level of the indexed deque list: command decode, the row of cells and the result register.
// Depends on idl_pkg, idl_cell and assert_macros.svh.
//
//   Channel   Ports                                          Handshake
//   command   i_kind, i_position_in, i_value                 start, busy
//   result    o_status, o_found, o_found_position,           o_valid strobe
//             o_front_value, o_back_value, o_count
//
// For each command the cells shift or compare in the cycle of the transfer,
// and the next cycle encodes the search hit and the back entry into the result register.
// The result appears on o_valid one cycle after that, and a new command may be taken then.
// busy is high during the encoding cycle only. Reset empties the list; the cells keep
// stale data that is never read. The receiver cannot stall the result.
`timescale 1ns / 1ps

module indexed_deque_list #(
    parameter int DEPTH      = idl_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = idl_pkg::DATA_WIDTH_DEF,
    parameter int CNT_W      = $clog2(DEPTH + 1),
    parameter int IDX_W      = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            i_kind,
    input  logic [CNT_W-1:0]      i_position_in,
    input  logic [DATA_WIDTH-1:0] i_value,
    output logic                  o_valid,
    output logic [1:0]            o_status,
    output logic                  o_found,
    output logic [IDX_W-1:0]      o_found_position,
    output logic [DATA_WIDTH-1:0] o_front_value,
    output logic [DATA_WIDTH-1:0] o_back_value,
    output logic [CNT_W-1:0]      o_count
);
    import idl_pkg::*;

    `include "assert_macros.svh"

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    t_state                r_state;
    t_state                n_state;
    logic                  w_accept;
    logic                  w_capture;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    t_status               r_status;
    t_status               n_status;
    t_cell_op              w_op;
    logic [CNT_W-1:0]      w_pos;
    t_cell_ctl             w_ctl;
    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    t_cell_stat            w_stat [DEPTH];
    logic                  w_found;
    logic [IDX_W-1:0]      w_found_pos;
    logic [DATA_WIDTH-1:0] w_back;
    logic                  r_valid;
    logic [1:0]            r_o_status;
    logic                  r_o_found;
    logic [IDX_W-1:0]      r_o_found_pos;
    logic [DATA_WIDTH-1:0] r_o_front;
    logic [DATA_WIDTH-1:0] r_o_back;
    logic [CNT_W-1:0]      r_o_count;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_REPORT;
                end
            end
            ST_REPORT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            ST_IDLE: begin
                busy      = 1'b0;
                w_capture = 1'b0;
            end
            ST_REPORT: begin
                busy      = 1'b1;
                w_capture = 1'b1;
            end
            default: begin
                busy      = 1'b0;
                w_capture = 1'b0;
            end
        endcase
    end

    assign w_accept = start && !busy;

    always_comb begin
        n_count  = r_count;
        n_status = STAT_OK;
        w_op     = CELL_HOLD;
        w_pos    = '0;
        case (t_kind'(i_kind))
            KIND_PUSH_FRONT: begin
                if (r_count == DEPTH_C) begin
                    n_status = STAT_FULL;
                end else begin
                    w_op    = CELL_INSERT;
                    n_count = r_count + ONE_C;
                end
            end
            KIND_PUSH_BACK: begin
                if (r_count == DEPTH_C) begin
                    n_status = STAT_FULL;
                end else begin
                    w_op    = CELL_INSERT;
                    w_pos   = r_count;
                    n_count = r_count + ONE_C;
                end
            end
            KIND_POP_FRONT: begin
                if (r_count == '0) begin
                    n_status = STAT_EMPTY;
                end else begin
                    w_op    = CELL_ERASE;
                    n_count = r_count - ONE_C;
                end
            end
            KIND_POP_BACK: begin
                if (r_count == '0) begin
                    n_status = STAT_EMPTY;
                end else begin
                    w_op    = CELL_ERASE;
                    w_pos   = r_count - ONE_C;
                    n_count = r_count - ONE_C;
                end
            end
            KIND_INSERT: begin
                if (i_position_in > r_count) begin
                    n_status = STAT_RANGE;
                end else if (r_count == DEPTH_C) begin
                    n_status = STAT_FULL;
                end else begin
                    w_op    = CELL_INSERT;
                    w_pos   = i_position_in;
                    n_count = r_count + ONE_C;
                end
            end
            KIND_ERASE: begin
                if (r_count == '0) begin
                    n_status = STAT_EMPTY;
                end else if (i_position_in >= r_count) begin
                    n_status = STAT_RANGE;
                end else begin
                    w_op    = CELL_ERASE;
                    w_pos   = i_position_in;
                    n_count = r_count - ONE_C;
                end
            end
            KIND_SEARCH: begin
                if (r_count == '0) begin
                    n_status = STAT_EMPTY;
                end else begin
                    w_op = CELL_SEARCH;
                end
            end
            KIND_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    assign w_ctl.op    = w_accept ? w_op : CELL_HOLD;
    assign w_ctl.write = w_accept && ((w_op == CELL_INSERT) || (w_op == CELL_ERASE));

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_inner_l
            assign w_left = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner_r
            assign w_right = w_data[g+1];
        end

        idl_cell #(
            .DATA_WIDTH(DATA_WIDTH),
            .CNT_W     (CNT_W),
            .IDX       (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (w_ctl),
            .i_pos  (w_pos),
            .i_count(r_count),
            .i_key  (i_value),
            .i_left (w_left),
            .i_right(w_right),
            .o_data (w_data[g]),
            .o_stat (w_stat[g])
        );
    end

    always_comb begin
        w_found     = 1'b0;
        w_found_pos = '0;
        w_back      = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (w_stat[i].match) begin
                w_found     = 1'b1;
                w_found_pos = IDX_W'(i);
            end
        end
        for (int i = 0; i < DEPTH; i++) begin
            w_back = w_back | (w_data[i] & {DATA_WIDTH{w_stat[i].last}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= w_capture;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
        end
        if (w_capture) begin
            r_o_status    <= r_status;
            r_o_found     <= w_found;
            r_o_found_pos <= w_found_pos;
            r_o_front     <= (r_count == '0) ? '0 : w_data[0];
            r_o_back      <= w_back;
            r_o_count     <= r_count;
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_o_status;
    assign o_found          = r_o_found;
    assign o_found_position = r_o_found_pos;
    assign o_front_value    = r_o_front;
    assign o_back_value     = r_o_back;
    assign o_count          = r_o_count;

    `ASSERT_CLK(a_result_follows, (start && !busy) |-> ##2 o_valid, "Command transfer gave no result.")
    `ASSERT_CLK(a_busy_one_cycle, busy |=> !busy, "Busy held for more than one cycle.")
    `ASSERT_NOW(a_count_bound, r_count <= DEPTH_C, "Element count exceeds the depth.")
    `ASSERT_NOW(a_hit_ok, (o_valid && o_found) |-> (o_status == STAT_OK), "Search hit with a bad status.")
    `ASSERT_NOW(a_empty_zero, (o_valid && (o_count == '0)) |-> ((o_front_value == '0) && (o_back_value == '0)), "Empty list shows data.")

endmodule

// ----- sim/idl_checker.sv -----
// Checker for the indexed deque list: watches command and result transfers, predicts each result.
// Depends on idl_pkg; instantiated beside the block by indexed_deque_list_tb.
`timescale 1ns / 1ps

module idl_checker #(
    parameter int DEPTH      = idl_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = idl_pkg::DATA_WIDTH_DEF,
    parameter int CNT_W      = $clog2(DEPTH + 1),
    parameter int IDX_W      = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [2:0]            i_kind,
    input  logic [CNT_W-1:0]      i_position_in,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic                  i_valid,
    input  logic [1:0]            i_status,
    input  logic                  i_found,
    input  logic [IDX_W-1:0]      i_found_position,
    input  logic [DATA_WIDTH-1:0] i_front_value,
    input  logic [DATA_WIDTH-1:0] i_back_value,
    input  logic [CNT_W-1:0]      i_count,
    output int                    o_error_count,
    output int                    o_outstanding
);
    import idl_pkg::*;

    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        t_status               status;
        logic                  found;
        logic [IDX_W-1:0]      found_position;
        logic [DATA_WIDTH-1:0] front_value;
        logic [DATA_WIDTH-1:0] back_value;
        logic [CNT_W-1:0]      count;
    } t_list_result;

    logic [DATA_WIDTH-1:0] list_vals [DEPTH];
    int                    list_len = 0;
    t_list_result          pending_results [$];
    int                    errors = 0;
    int                    result_index = 0;

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= PRINT_LIMIT) begin
            $display("%0t ns: result %0d: %s", $time, result_index, msg);
        end
    endtask

    task automatic check_field(string name, logic [DATA_WIDTH-1:0] got,
                               logic [DATA_WIDTH-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    function automatic void open_slot(int at, logic [DATA_WIDTH-1:0] val);
        for (int i = list_len; i > at; i--) begin
            list_vals[i] = list_vals[i-1];
        end
        list_vals[at] = val;
        list_len++;
    endfunction

    function automatic void close_slot(int at);
        for (int i = at; i + 1 < list_len; i++) begin
            list_vals[i] = list_vals[i+1];
        end
        list_len--;
    endfunction

    function automatic t_list_result apply_list_command(t_kind kind, logic [CNT_W-1:0] pos,
                                                        logic [DATA_WIDTH-1:0] val);
        t_list_result res;
        res = '0;
        res.status = STAT_OK;
        case (kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                if (list_len >= DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    open_slot((kind == KIND_PUSH_FRONT) ? 0 : list_len, val);
                end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
                if (list_len == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    close_slot((kind == KIND_POP_FRONT) ? 0 : list_len - 1);
                end
            end
            KIND_INSERT: begin
                if (int'(pos) > list_len) begin
                    res.status = STAT_RANGE;
                end else if (list_len >= DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    open_slot(int'(pos), val);
                end
            end
            KIND_ERASE: begin
                if (list_len == 0) begin
                    res.status = STAT_EMPTY;
                end else if (int'(pos) >= list_len) begin
                    res.status = STAT_RANGE;
                end else begin
                    close_slot(int'(pos));
                end
            end
            KIND_SEARCH: begin
                if (list_len == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    for (int i = 0; i < list_len; i++) begin
                        if (list_vals[i] == val) begin
                            res.found = 1'b1;
                            res.found_position = IDX_W'(i);
                            break;
                        end
                    end
                end
            end
            default: begin
                list_len = 0;
            end
        endcase
        res.count = CNT_W'(list_len);
        if (list_len != 0) begin
            res.front_value = list_vals[0];
            res.back_value = list_vals[list_len-1];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_list_result want;
        if (!i_rst_n) begin
            list_len = 0;
            pending_results.delete();
        end else begin
            if (i_valid) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result arrived with no command outstanding");
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    check_field("status", i_status, want.status);
                    check_field("found", i_found, want.found);
                    check_field("found_position", i_found_position, want.found_position);
                    check_field("front_value", i_front_value, want.front_value);
                    check_field("back_value", i_back_value, want.back_value);
                    check_field("count", i_count, want.count);
                end
                result_index++;
            end
            if (i_start && !i_busy) begin
                pending_results = {pending_results,
                                   apply_list_command(t_kind'(i_kind), i_position_in,
                                                      i_value)};
            end
        end
        o_outstanding <= pending_results.size();
        o_error_count <= errors;
    end

endmodule

// ----- sim/indexed_deque_list_tb.sv -----
// Testbench top for the indexed deque list: clock, reset, command stimulus and the verdict.
// Depends on idl_pkg, indexed_deque_list and idl_checker.
`timescale 1ns / 1ps

module indexed_deque_list_tb;
    import idl_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int DATA_WIDTH   = DATA_WIDTH_DEF;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int RANDOM_ITEMS = 650;
    localparam int MAX_GAP      = 13;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 4;

    typedef enum logic [1:0] {
        PHASE_GROW,
        PHASE_SHRINK,
        PHASE_MIXED
    } t_phase;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [2:0]            i_kind = KIND_SEARCH;
    logic [CNT_W-1:0]      i_position_in = '0;
    logic [DATA_WIDTH-1:0] i_value = '0;
    logic                  o_valid;
    logic [1:0]            o_status;
    logic                  o_found;
    logic [IDX_W-1:0]      o_found_position;
    logic [DATA_WIDTH-1:0] o_front_value;
    logic [DATA_WIDTH-1:0] o_back_value;
    logic [CNT_W-1:0]      o_count;
    int                    error_count;
    int                    outstanding;
    int                    idle_cycles = 0;
    logic [DATA_WIDTH-1:0] key_pool [8];

    indexed_deque_list #(
        .DEPTH(DEPTH),
        .DATA_WIDTH(DATA_WIDTH)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_kind(i_kind),
        .i_position_in(i_position_in),
        .i_value(i_value),
        .o_valid(o_valid),
        .o_status(o_status),
        .o_found(o_found),
        .o_found_position(o_found_position),
        .o_front_value(o_front_value),
        .o_back_value(o_back_value),
        .o_count(o_count)
    );

    idl_checker #(
        .DEPTH(DEPTH),
        .DATA_WIDTH(DATA_WIDTH)
    ) checker_inst (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_busy(busy),
        .i_kind(i_kind),
        .i_position_in(i_position_in),
        .i_value(i_value),
        .i_valid(o_valid),
        .i_status(o_status),
        .i_found(o_found),
        .i_found_position(o_found_position),
        .i_front_value(o_front_value),
        .i_back_value(o_back_value),
        .i_count(o_count),
        .o_error_count(error_count),
        .o_outstanding(outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_command(t_kind kind, int pos,
                                logic [DATA_WIDTH-1:0] val, int gap);
        repeat (gap) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_kind <= kind;
        i_position_in <= CNT_W'(pos);
        i_value <= val;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic t_kind pick_kind(t_phase phase);
        int r;
        r = $urandom_range(0, 99);
        case (phase)
            PHASE_GROW: begin
                if (r < 30) return KIND_PUSH_BACK;
                if (r < 55) return KIND_PUSH_FRONT;
                if (r < 80) return KIND_INSERT;
                if (r < 90) return KIND_SEARCH;
                if (r < 95) return KIND_ERASE;
                return KIND_POP_BACK;
            end
            PHASE_SHRINK: begin
                if (r < 20) return KIND_POP_FRONT;
                if (r < 40) return KIND_POP_BACK;
                if (r < 65) return KIND_ERASE;
                if (r < 80) return KIND_SEARCH;
                if (r < 92) return KIND_PUSH_BACK;
                if (r < 97) return KIND_INSERT;
                return KIND_CLEAR;
            end
            default: begin
                if (r < 3) return KIND_CLEAR;
                return t_kind'($urandom_range(0, 6));
            end
        endcase
    endfunction

    function automatic int pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return int'($urandom_range(0, 4));
        if (r < 80) return int'($urandom_range(0, DEPTH));
        return int'($urandom_range(0, (1 << CNT_W) - 1));
    endfunction

    function automatic logic [DATA_WIDTH-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return key_pool[$urandom_range(0, 7)];
        if (r < 50) return ($urandom_range(0, 1) == 1) ? '1 : '0;
        return DATA_WIDTH'($urandom);
    endfunction

    initial begin : stimulus
        int     sent;
        int     phase_len;
        bit     no_gaps;
        t_phase phase;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty list: every operation that needs an element must fail.
        send_command(KIND_SEARCH, 0, 32'h0000_0000, 0);
        send_command(KIND_POP_FRONT, 0, 32'h0, 0);
        send_command(KIND_POP_BACK, 0, 32'h0, 0);
        send_command(KIND_ERASE, 0, 32'h0, 0);
        send_command(KIND_INSERT, 1, 32'h1111_1111, 0);
        send_command(KIND_INSERT, 0, 32'hFFFF_FFFF, 0);
        send_command(KIND_PUSH_BACK, 0, 32'h0000_0000, 0);
        send_command(KIND_PUSH_FRONT, 0, 32'h1234_5678, 0);
        send_command(KIND_PUSH_BACK, 0, 32'hFFFF_FFFF, 0);
        // A duplicated key must report its lowest position.
        send_command(KIND_SEARCH, 0, 32'hFFFF_FFFF, 0);
        send_command(KIND_SEARCH, 0, 32'h0000_0000, 0);
        send_command(KIND_SEARCH, 0, 32'h5A5A_5A5A, 0);
        send_command(KIND_ERASE, 4, 32'h0, 0);
        send_command(KIND_ERASE, 31, 32'h0, 0);
        send_command(KIND_INSERT, 31, 32'h0, 0);
        send_command(KIND_INSERT, 4, 32'hA5A5_A5A5, 0);
        send_command(KIND_INSERT, 2, 32'h8000_0001, 0);
        send_command(KIND_ERASE, 1, 32'h0, 0);
        send_command(KIND_POP_FRONT, 0, 32'h0, 0);
        send_command(KIND_POP_BACK, 0, 32'h0, 0);
        send_command(KIND_CLEAR, 0, 32'h0, 0);
        send_command(KIND_CLEAR, 0, 32'h0, 0);

        sent = 0;
        phase = PHASE_GROW;
        while (sent < RANDOM_ITEMS) begin
            phase_len = (sent == 0) ? 40 : $urandom_range(20, 50);
            no_gaps = ($urandom_range(0, 2) == 0);
            foreach (key_pool[k]) begin
                key_pool[k] = DATA_WIDTH'($urandom);
            end
            repeat (phase_len) begin
                send_command(pick_kind(phase), pick_position(), pick_value(),
                             no_gaps ? 0 : $urandom_range(0, MAX_GAP));
                sent++;
            end
            phase = t_phase'($urandom_range(0, 2));
        end

        start <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
